/* rtl/usbpd_pkg.sv */
// Shared types, codes and helpers for the USB PD sink protocol layer.
package usbpd_pkg;

    typedef enum logic [2:0] {
        CMD_RX_HDR   = 3'd0,
        CMD_RX_OBJ   = 3'd1,
        CMD_GET_SRC  = 3'd2,
        CMD_REQUEST  = 3'd3,
        CMD_GET_PPS  = 3'd4,
        CMD_PRST     = 3'd5,
        CMD_SELECT   = 3'd6,
        CMD_NOP      = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_STATUS,
        S_REQ_RD,
        S_HDR,
        S_OBJ
    } t_state;

    typedef enum logic [2:0] {
        RP_NONE,
        RP_NOTSUP,
        RP_REJECT,
        RP_ACCEPT,
        RP_SINKCAP,
        RP_REQUEST,
        RP_GETSRC,
        RP_GETPPS
    } t_reply;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_HDR    = 2'd1;
    localparam logic [1:0] KIND_OBJ    = 2'd2;

    localparam logic [2:0] CFG_POWER_OPTION = 3'd0;
    localparam logic [2:0] CFG_PPS_VOLTAGE  = 3'd1;
    localparam logic [2:0] CFG_PPS_CURRENT  = 3'd2;

    localparam logic [4:0] MT_NOT_SUPPORTED = 5'h10;
    localparam logic [4:0] MT_REJECT        = 5'h04;
    localparam logic [4:0] MT_ACCEPT        = 5'h03;
    localparam logic [4:0] MT_SINK_CAP      = 5'h04;
    localparam logic [4:0] MT_REQUEST       = 5'h02;
    localparam logic [4:0] MT_GET_SRC_CAP   = 5'h07;
    localparam logic [4:0] MT_GET_PPS       = 5'h14;

    localparam logic [31:0] SINK_CAP_PDO = 32'd100 | (32'd100 << 10) | (32'd1 << 26)
                                         | (32'd1 << 28);

    function automatic logic [13:0] power_limit(input logic [2:0] row);
        case (row)
            3'd0:    power_limit = 14'd25;
            3'd1:    power_limit = 14'd45;
            3'd2:    power_limit = 14'd60;
            3'd3:    power_limit = 14'd75;
            3'd4:    power_limit = 14'd100;
            3'd5:    power_limit = 14'd100;
            3'd6:    power_limit = 14'd125;
            default: power_limit = 14'd12500;
        endcase
    endfunction

    function automatic logic [31:0] make_hdr(input logic [4:0] mtype, input logic [2:0] id,
                                             input logic cnt);
        make_hdr = {16'd0, 1'b0, 2'b00, cnt, id, 3'b010, 1'b0, mtype};
    endfunction

endpackage

/* rtl/usb_pd_sink_protocol_layer_core.sv */
// USB PD sink protocol layer: message decode, PDO store and scan, reply generation.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  in       | i_valid / o_ready  | i_command, i_data_word, i_pdo_index
//  out      | o_valid / i_ready  | o_kind, o_tx_word, o_last, events, status
//  cfg      | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One word at a time: a word is taken only in the idle state.
// A result word is registered; Source_Capabilities scans the PDO memory one stored
// PDO at a time (read, then evaluate), and stops early at a matching PPS PDO.
// A Request reads the selected PDO first (S_REQ_RD), before its header goes out.
// Stalls on the output hold the state machine. Reset is synchronous, no clearing pass.
module usb_pd_sink_protocol_layer_core
    import usbpd_pkg::*;
#(
    parameter int MAX_SOURCE_PDOS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_pdo_index,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_tx_word,
    output logic        o_last,
    output logic        o_event_accept,
    output logic        o_event_ps_ready,
    output logic        o_event_source_caps,
    output logic        o_event_pps_status,
    output logic [2:0]  o_selected_pdo,
    output logic [2:0]  o_current_message_id,
    output logic [15:0] o_pps_out_voltage,
    output logic [7:0]  o_pps_out_current,
    output logic [2:0]  o_pps_flags
);

    localparam int AW = (MAX_SOURCE_PDOS > 1) ? $clog2(MAX_SOURCE_PDOS) : 1;
    localparam logic [2:0] MAXP = 3'(MAX_SOURCE_PDOS);

    logic [31:0] mem [MAX_SOURCE_PDOS];
    logic [31:0] r_rd_data;

    t_state r_state, n_state;
    t_reply r_reply, n_reply;
    logic [3:0]  r_ev, n_ev;
    logic [2:0]  r_power, r_count, n_count, r_sel, n_sel, r_msg_id, n_msg_id;
    logic [2:0]  r_objrem, n_objrem, r_scan, n_scan, r_cand, n_cand;
    logic [10:0] r_pvu;
    logic [6:0]  r_pcu;
    logic [15:0] r_hdr, n_hdr;
    logic [31:0] r_psb, n_psb;

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [31:0] r_tx, n_tx;
    logic        r_last, n_last;
    logic [3:0]  r_oev, n_oev;
    logic [2:0]  r_osel, n_osel, r_oid, n_oid, r_oflags, n_oflags;
    logic [15:0] r_ovolt, n_ovolt;
    logic [7:0]  r_ocur, n_ocur;

    logic        wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;

    logic        accept, out_free, fin;
    logic [15:0] h;
    logic [4:0]  htype;
    logic [2:0]  hnum, pos;
    logic [3:0]  fin_ev;
    t_reply      fin_reply;
    logic        fin_caps, fin_gcrc;

    logic [1:0]  ptype;
    logic [11:0] pv, minv5, maxv5;
    logic [9:0]  pi, maxi5;
    logic [9:0]  maxv, maxi;
    logic [7:0]  fv, fi;
    logic [15:0] prod;
    logic        pps_hit, fix_hit;
    logic [9:0]  req;
    logic [2:0]  rpos;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign h     = (t_cmd'(i_command) == CMD_RX_HDR) ? i_data_word[15:0] : r_hdr;
    assign htype = h[4:0];
    assign hnum  = h[14:12];
    assign pos   = hnum - r_objrem;

    always_comb begin
        fin_ev    = 4'd0;
        fin_reply = RP_NONE;
        fin_caps  = 1'b0;
        fin_gcrc  = 1'b0;
        if (h[15]) begin
            if (htype == 5'd12) begin
                fin_ev[3] = 1'b1;
            end else if (htype inside {5'd0, 5'd3, 5'd4, 5'd6, 5'd8, 5'd10, [5'd15:5'd31]}) begin
                fin_reply = RP_NOTSUP;
            end
        end else if (hnum != 3'd0) begin
            if (htype == 5'd1) begin
                fin_caps  = 1'b1;
                fin_ev[2] = 1'b1;
                fin_reply = RP_REQUEST;
            end else if (htype inside {5'd2, 5'd4, 5'd5, 5'd7, [5'd16:5'd31]}) begin
                fin_reply = RP_NOTSUP;
            end
        end else begin
            case (htype)
                5'd1:        fin_gcrc  = 1'b1;
                5'd3:        fin_ev[0] = 1'b1;
                5'd4, 5'd6:  fin_ev[1] = 1'b1;
                5'd8:        fin_reply = RP_SINKCAP;
                5'd9, 5'd11: fin_reply = RP_REJECT;
                5'd13:       fin_reply = RP_ACCEPT;
                default: begin
                    if (htype inside {5'd7, 5'd10, [5'd17:5'd21], [5'd23:5'd31]}) begin
                        fin_reply = RP_NOTSUP;
                    end
                end
            endcase
        end
    end

    // PDO evaluation on the word just read
    always_comb begin
        ptype = r_rd_data[31:30];
        pv    = {r_pvu, 1'b0};
        pi    = 10'(r_pcu) * 10'd5;
        minv5 = 12'(r_rd_data[15:8]) * 12'd10;
        maxv5 = 12'(r_rd_data[24:17]) * 12'd10;
        maxi5 = 10'(r_rd_data[6:0]) * 10'd5;
        pps_hit = (minv5 <= pv) && (pv <= maxv5) && (pi <= maxi5);
        maxv = (ptype == 2'd0) ? r_rd_data[19:10] : r_rd_data[29:20];
        maxi = (ptype == 2'd1) ? 10'd0 : r_rd_data[9:0];
        fv   = (r_power != 3'd6) ? maxv[9:2] : 8'd1;
        fi   = (r_power inside {3'd6, 3'd7}) ? maxi[9:2] : 8'd1;
        prod = fv * fi;
        fix_hit = (prod <= 16'(power_limit(r_power)));
        req  = (r_sel < r_count) ? r_rd_data[9:0] : 10'd0;
        rpos = r_sel + 3'd1;
    end

    always_comb begin
        n_state  = r_state;
        n_reply  = r_reply;
        n_ev     = r_ev;
        n_count  = r_count;
        n_sel    = r_sel;
        n_msg_id = r_msg_id;
        n_objrem = r_objrem;
        n_scan   = r_scan;
        n_cand   = r_cand;
        n_hdr    = r_hdr;
        n_psb    = r_psb;
        n_out_valid = r_out_valid && !i_ready;
        n_kind   = r_kind;
        n_tx     = r_tx;
        n_last   = r_last;
        n_oev    = r_oev;
        n_osel   = r_osel;
        n_oid    = r_oid;
        n_ovolt  = r_ovolt;
        n_ocur   = r_ocur;
        n_oflags = r_oflags;
        wr_en    = 1'b0;
        wr_addr  = pos[AW-1:0];
        rd_en    = 1'b0;
        rd_addr  = r_sel[AW-1:0];
        fin      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_RX_HDR: begin
                            n_hdr    = i_data_word[15:0];
                            n_objrem = i_data_word[14:12];
                            fin      = (i_data_word[14:12] == 3'd0);
                        end
                        CMD_RX_OBJ: begin
                            if (r_objrem != 3'd0) begin
                                if (h[15]) begin
                                    if (htype == 5'd12 && pos == 3'd0) begin
                                        n_psb[15:0] = i_data_word[31:16];
                                    end else if (htype == 5'd12 && pos == 3'd1) begin
                                        n_psb[31:16] = i_data_word[15:0];
                                    end
                                end else if (htype == 5'd1 && pos < MAXP) begin
                                    wr_en = 1'b1;
                                end
                                n_objrem = r_objrem - 3'd1;
                                fin      = (r_objrem == 3'd1);
                            end
                        end
                        CMD_GET_SRC: begin
                            n_reply = RP_GETSRC;
                            n_state = S_HDR;
                        end
                        CMD_REQUEST: begin
                            n_reply = RP_REQUEST;
                            n_state = S_REQ_RD;
                        end
                        CMD_GET_PPS: begin
                            n_reply = RP_GETPPS;
                            n_state = S_HDR;
                        end
                        CMD_PRST: begin
                            n_msg_id = 3'd0;
                            n_objrem = 3'd0;
                            n_ev     = 4'd0;
                            n_reply  = RP_NONE;
                            n_state  = S_STATUS;
                        end
                        CMD_SELECT: begin
                            if (i_pdo_index < r_count) begin
                                n_sel = i_pdo_index;
                            end
                            n_ev    = 4'd0;
                            n_reply = RP_NONE;
                            n_state = S_STATUS;
                        end
                        default: begin
                        end
                    endcase
                    if (fin) begin
                        n_ev    = fin_ev;
                        n_reply = fin_reply;
                        if (fin_gcrc) begin
                            n_msg_id = r_msg_id + 3'd1;
                        end
                        if (fin_caps) begin
                            n_count = (hnum > MAXP) ? MAXP : hnum;
                            n_scan  = 3'd0;
                            n_cand  = 3'd0;
                            n_state = S_SCAN_RD;
                        end else begin
                            n_state = S_STATUS;
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_scan[AW-1:0];
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (ptype == 2'd3 && pps_hit) begin
                    n_sel   = r_scan;
                    n_state = S_STATUS;
                end else begin
                    if (ptype != 2'd3 && fix_hit) begin
                        n_cand = r_scan;
                    end
                    n_scan = r_scan + 3'd1;
                    if (r_scan + 3'd1 >= r_count) begin
                        n_sel   = (ptype != 2'd3 && fix_hit) ? r_scan : r_cand;
                        n_state = S_STATUS;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind   = KIND_STATUS;
                    n_tx     = 32'd0;
                    n_last   = (r_reply == RP_NONE);
                    n_oev    = r_ev;
                    n_osel   = r_sel;
                    n_oid    = r_msg_id;
                    n_ovolt  = r_psb[15:0];
                    n_ocur   = r_psb[23:16];
                    n_oflags = {r_psb[27], r_psb[26:25]};
                    case (r_reply)
                        RP_NONE:    n_state = S_IDLE;
                        RP_REQUEST: n_state = S_REQ_RD;
                        default:    n_state = S_HDR;
                    endcase
                end
            end
            S_REQ_RD: begin
                rd_en   = 1'b1;
                n_state = S_HDR;
            end
            S_HDR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind   = KIND_HDR;
                    n_oev    = 4'd0;
                    n_osel   = 3'd0;
                    n_oid    = 3'd0;
                    n_ovolt  = 16'd0;
                    n_ocur   = 8'd0;
                    n_oflags = 3'd0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                    case (r_reply)
                        RP_NOTSUP:  n_tx = make_hdr(MT_NOT_SUPPORTED, r_msg_id, 1'b0);
                        RP_REJECT:  n_tx = make_hdr(MT_REJECT, r_msg_id, 1'b0);
                        RP_ACCEPT:  n_tx = make_hdr(MT_ACCEPT, r_msg_id, 1'b0);
                        RP_GETSRC:  n_tx = make_hdr(MT_GET_SRC_CAP, r_msg_id, 1'b0);
                        RP_GETPPS:  n_tx = make_hdr(MT_GET_PPS, r_msg_id, 1'b0);
                        RP_SINKCAP: begin
                            n_tx    = make_hdr(MT_SINK_CAP, r_msg_id, 1'b1);
                            n_last  = 1'b0;
                            n_state = S_OBJ;
                        end
                        default: begin
                            n_tx    = make_hdr(MT_REQUEST, r_msg_id, 1'b1);
                            n_last  = 1'b0;
                            n_state = S_OBJ;
                        end
                    endcase
                end
            end
            S_OBJ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind  = KIND_OBJ;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                    if (r_reply == RP_SINKCAP) begin
                        n_tx = SINK_CAP_PDO;
                    end else if (r_sel < r_count && ptype == 2'd3) begin
                        n_tx = {1'b0, rpos, 2'b00, 1'b1, 5'd0, r_pvu, 2'b00, r_pcu};
                    end else begin
                        n_tx = {1'b0, rpos, 2'b00, 1'b1, 5'd0, req, req};
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_data_word;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reply     <= RP_NONE;
            r_ev        <= 4'd0;
            r_count     <= 3'd0;
            r_sel       <= 3'd0;
            r_msg_id    <= 3'd0;
            r_objrem    <= 3'd0;
            r_scan      <= 3'd0;
            r_cand      <= 3'd0;
            r_hdr       <= 16'd0;
            r_psb       <= 32'd0;
            r_out_valid <= 1'b0;
            r_power     <= 3'd0;
            r_pvu       <= 11'd0;
            r_pcu       <= 7'd0;
        end else begin
            r_state     <= n_state;
            r_reply     <= n_reply;
            r_ev        <= n_ev;
            r_count     <= n_count;
            r_sel       <= n_sel;
            r_msg_id    <= n_msg_id;
            r_objrem    <= n_objrem;
            r_scan      <= n_scan;
            r_cand      <= n_cand;
            r_hdr       <= n_hdr;
            r_psb       <= n_psb;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case ({1'b0, i_cfg_index})
                    CFG_POWER_OPTION: r_power <= i_cfg_data[2:0];
                    CFG_PPS_VOLTAGE:  r_pvu   <= i_cfg_data;
                    CFG_PPS_CURRENT:  r_pcu   <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_tx     <= n_tx;
        r_last   <= n_last;
        r_oev    <= n_oev;
        r_osel   <= n_osel;
        r_oid    <= n_oid;
        r_ovolt  <= n_ovolt;
        r_ocur   <= n_ocur;
        r_oflags <= n_oflags;
    end

    assign o_valid              = r_out_valid;
    assign o_kind               = r_kind;
    assign o_tx_word            = r_tx;
    assign o_last               = r_last;
    assign o_event_accept       = r_oev[0];
    assign o_event_ps_ready     = r_oev[1];
    assign o_event_source_caps  = r_oev[2];
    assign o_event_pps_status   = r_oev[3];
    assign o_selected_pdo       = r_osel;
    assign o_current_message_id = r_oid;
    assign o_pps_out_voltage    = r_ovolt;
    assign o_pps_out_current    = r_ocur;
    assign o_pps_flags          = r_oflags;

    a_msg_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_msg_id != $past(r_msg_id)) |->
        (r_msg_id == $past(r_msg_id) + 3'd1 || r_msg_id == 3'd0))
        else $error("message ID jumped");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXP)
        else $error("PDO count beyond store depth");

    a_sel_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_sel < r_count || r_sel == 3'd0))
        else $error("selected PDO outside stored range");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_RD) |-> (r_scan < r_count))
        else $error("PDO scan past count");

endmodule

/* verif/tb_top.sv */
// Testbench for the USB PD sink protocol layer core: scoreboard, drivers and checks.
module tb_top
    import usbpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tx_word;
        logic        last;
        logic        ev_accept;
        logic        ev_ps_ready;
        logic        ev_src_caps;
        logic        ev_pps_status;
        logic [2:0]  sel_pdo;
        logic [2:0]  msg_id;
        logic [15:0] pps_volt;
        logic [7:0]  pps_curr;
        logic [2:0]  pps_flags;
    } pd_word_t;

    typedef struct {
        int unsigned typ, minv, maxv, maxi, maxp;
    } pdo_info_t;

    class pd_scoreboard;
        bit [2:0]    power_opt;
        bit [10:0]   volt_req;
        bit [6:0]    curr_req;
        bit [31:0]   pdo_mem [7];
        int unsigned pdo_cnt, sel_idx, msg_id, pending;
        bit [15:0]   rx_hdr;
        bit [31:0]   pps_bytes;
        pd_word_t    pending_words[$];
        int          errors, words_in, words_out, caps_seen, pps_seen;

        function void report(string msg);
            $display("tb_top mismatch: %s", msg);
            errors++;
        endfunction

        function void set_reg(bit [2:0] idx, bit [10:0] val);
            if (idx == CFG_POWER_OPTION) power_opt = val[2:0];
            else if (idx == CFG_PPS_VOLTAGE) volt_req = val;
            else if (idx == CFG_PPS_CURRENT) curr_req = val[6:0];
        endfunction

        function pdo_info_t decode(int unsigned idx);
            pdo_info_t p;
            bit [31:0] o;
            p = '{0, 0, 0, 0, 0};
            if (idx >= pdo_cnt || idx >= 7) return p;
            o = pdo_mem[idx];
            p.typ = o[31:30];
            case (p.typ)
                0: begin
                    p.maxv = o[19:10];
                    p.maxi = o[9:0];
                end
                1: begin
                    p.minv = o[19:10];
                    p.maxv = o[29:20];
                    p.maxp = o[9:0];
                end
                2: begin
                    p.minv = o[19:10];
                    p.maxv = o[29:20];
                    p.maxi = o[9:0];
                end
                default: begin
                    p.maxv = o[24:17] * 2;
                    p.minv = o[15:8] * 2;
                    p.maxi = o[6:0] * 5;
                end
            endcase
            return p;
        endfunction

        function int unsigned pick_pdo();
            int unsigned lim [8] = '{25, 45, 60, 75, 100, 100, 125, 12500};
            int unsigned pv, pc, v, c, best;
            pdo_info_t p;
            pv = volt_req * 2;
            pc = curr_req * 5;
            best = 0;
            for (int unsigned n = 0; n < pdo_cnt && n < 7; n++) begin
                p = decode(n);
                if (p.typ == 3) begin
                    if (p.minv * 5 <= pv && pv <= p.maxv * 5 && pc <= p.maxi) return n;
                end else begin
                    v = (power_opt != 6) ? (p.maxv >> 2) : 1;
                    c = (power_opt >= 6) ? (p.maxi >> 2) : 1;
                    if (v * c <= lim[power_opt]) best = n;
                end
            end
            return best;
        endfunction

        function bit [31:0] hdr_word(bit [4:0] mt, bit cnt);
            return {16'd0, 1'b0, 2'b00, cnt, msg_id[2:0], 3'b010, 1'b0, mt};
        endfunction

        function bit [31:0] request_obj();
            pdo_info_t p;
            bit [31:0] pos, req;
            p = decode(sel_idx);
            pos = (sel_idx + 1) & 7;
            if (p.typ == 3)
                return {25'd0, curr_req} | ({21'd0, volt_req} << 9) | (1 << 25) | (pos << 28);
            req = p.maxi ? p.maxi : p.maxp;
            return req | (req << 10) | (1 << 25) | (pos << 28);
        endfunction

        function void push_tx(bit [1:0] kind, bit [31:0] w);
            pd_word_t r;
            r = '0;
            r.kind = kind;
            r.tx_word = w;
            pending_words.push_back(r);
        endfunction

        function void push_status(bit [3:0] ev);
            pd_word_t r;
            bit [7:0] b3;
            r = '0;
            b3 = pps_bytes[31:24];
            r.kind = KIND_STATUS;
            {r.ev_pps_status, r.ev_src_caps, r.ev_ps_ready, r.ev_accept} = ev;
            r.sel_pdo = sel_idx;
            r.msg_id = msg_id;
            r.pps_volt = pps_bytes[15:0];
            r.pps_curr = pps_bytes[23:16];
            r.pps_flags = {b3[3], b3[2:1]};
            pending_words.push_back(r);
        endfunction

        function void finish_msg();
            bit [4:0] t;
            int unsigned num;
            bit [3:0] ev;
            t = rx_hdr[4:0];
            num = rx_hdr[14:12];
            ev = 0;
            if (rx_hdr[15]) begin
                if (t == 12) ev[3] = 1;
                push_status(ev);
                if (t != 12 && (t == 0 || t == 3 || t == 4 || t == 6 || t == 8 || t == 10
                                || t >= 15))
                    push_tx(KIND_HDR, hdr_word(MT_NOT_SUPPORTED, 0));
            end else if (num != 0) begin
                if (t == 1) begin
                    pdo_cnt = num;
                    sel_idx = pick_pdo();
                    caps_seen++;
                    ev[2] = 1;
                    push_status(ev);
                    push_tx(KIND_HDR, hdr_word(MT_REQUEST, 1));
                    push_tx(KIND_OBJ, request_obj());
                end else begin
                    push_status(ev);
                    if (t == 2 || t == 4 || t == 5 || t == 7 || t >= 16)
                        push_tx(KIND_HDR, hdr_word(MT_NOT_SUPPORTED, 0));
                end
            end else begin
                if (t == 1) msg_id = (msg_id + 1) & 7;
                else if (t == 3) ev[0] = 1;
                else if (t == 4 || t == 6) ev[1] = 1;
                push_status(ev);
                if (t == 8) begin
                    push_tx(KIND_HDR, hdr_word(MT_SINK_CAP, 1));
                    push_tx(KIND_OBJ, SINK_CAP_PDO);
                end else if (t == 9 || t == 11) push_tx(KIND_HDR, hdr_word(MT_REJECT, 0));
                else if (t == 13) push_tx(KIND_HDR, hdr_word(MT_ACCEPT, 0));
                else if (t == 7 || t == 10 || (t >= 17 && t <= 21) || t >= 23)
                    push_tx(KIND_HDR, hdr_word(MT_NOT_SUPPORTED, 0));
            end
        endfunction

        function void note_word(t_cmd cmd, bit [31:0] w, bit [2:0] idx);
            int before_n;
            int unsigned pos;
            before_n = pending_words.size();
            words_in++;
            case (cmd)
                CMD_RX_HDR: begin
                    rx_hdr = w[15:0];
                    pending = rx_hdr[14:12];
                    if (pending == 0) finish_msg();
                end
                CMD_RX_OBJ: begin
                    if (pending != 0) begin
                        pos = (rx_hdr[14:12] - pending) & 7;
                        if (rx_hdr[15]) begin
                            if (rx_hdr[4:0] == 12) begin
                                if (pos == 0) pps_bytes[15:0] = w[31:16];
                                else if (pos == 1) pps_bytes[31:16] = w[15:0];
                                if (pending == 1) pps_seen++;
                            end
                        end else if (rx_hdr[4:0] == 1 && pos < 7) pdo_mem[pos] = w;
                        pending--;
                        if (pending == 0) finish_msg();
                    end
                end
                CMD_GET_SRC: push_tx(KIND_HDR, hdr_word(MT_GET_SRC_CAP, 0));
                CMD_REQUEST: begin
                    push_tx(KIND_HDR, hdr_word(MT_REQUEST, 1));
                    push_tx(KIND_OBJ, request_obj());
                end
                CMD_GET_PPS: push_tx(KIND_HDR, hdr_word(MT_GET_PPS, 0));
                CMD_PRST: begin
                    msg_id = 0;
                    pending = 0;
                    push_status(0);
                end
                CMD_SELECT: begin
                    if (idx < pdo_cnt) sel_idx = idx;
                    push_status(0);
                end
                default: ;
            endcase
            if (pending_words.size() > before_n)
                pending_words[pending_words.size() - 1].last = 1;
        endfunction

        function void check_word(pd_word_t got);
            pd_word_t exp;
            words_out++;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word %p", got));
                return;
            end
            exp = pending_words.pop_front();
            if (got !== exp) report($sformatf("got %p expected %p", got, exp));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [2:0]  i_command = 0;
    logic [31:0] i_data_word = 0;
    logic [2:0]  i_pdo_index = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [10:0] i_cfg_data = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_kind;
    logic [31:0] o_tx_word;
    logic        o_last;
    logic        o_event_accept, o_event_ps_ready, o_event_source_caps, o_event_pps_status;
    logic [2:0]  o_selected_pdo, o_current_message_id;
    logic [15:0] o_pps_out_voltage;
    logic [7:0]  o_pps_out_current;
    logic [2:0]  o_pps_flags;

    pd_scoreboard sb = new();
    int tx_idle_pct, rx_stall_pct, hold_left, sent, idle_cycles;
    bit running;

    usb_pd_sink_protocol_layer_core dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_word(t_cmd'(i_command), i_data_word, i_pdo_index);
            if (o_valid && i_ready)
                sb.check_word({o_kind, o_tx_word, o_last, o_event_accept, o_event_ps_ready,
                               o_event_source_caps, o_event_pps_status, o_selected_pdo,
                               o_current_message_id, o_pps_out_voltage, o_pps_out_current,
                               o_pps_flags});
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 0;
            end else begin
                i_ready <= running && ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_word(t_cmd cmd, bit [31:0] w, bit [2:0] idx);
        @(negedge i_clk);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_command <= cmd;
        i_data_word <= w;
        i_pdo_index <= idx;
        i_valid <= 1;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (sb.pending_words.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(bit [2:0] idx, bit [10:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx[1:0];
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic bit [31:0] rand_pdo();
        bit [31:0] p;
        p = $urandom;
        if ($urandom_range(3) == 0) p[29:0] = $urandom_range(1, 3) << $urandom_range(0, 25);
        return p;
    endfunction

    task automatic send_msg(bit ext, bit [4:0] mt, int n, int objs);
        bit [31:0] h;
        h = $urandom;
        h[15] = ext;
        h[14:12] = n;
        h[4:0] = mt;
        send_word(CMD_RX_HDR, h, $urandom);
        for (int k = 0; k < objs; k++)
            send_word(CMD_RX_OBJ, (!ext && mt == 1) ? rand_pdo() : $urandom, $urandom);
    endtask

    task automatic random_msg();
        int r, n;
        r = $urandom_range(99);
        if (r < 30) begin
            send_msg(0, 1, $urandom_range(1, 7), 0);
        end else if (r < 42) begin
            n = $urandom_range(0, 3);
            send_msg(1, 12, n, n);
            return;
        end else if (r < 70) begin
            n = $urandom_range(0, 7);
            send_msg($urandom_range(1), $urandom, n, n);
            return;
        end else if (r < 78) begin
            n = $urandom_range(2, 7);
            send_msg($urandom_range(1), $urandom_range(1) ? 1 : 12, n, $urandom_range(1, n - 1));
            return;
        end else if (r < 94) begin
            send_word(t_cmd'($urandom_range(2, 6)), $urandom, $urandom);
            return;
        end else begin
            send_word($urandom_range(1) ? CMD_NOP : CMD_RX_OBJ, $urandom, $urandom);
            return;
        end
        // full Source_Capabilities: objects follow the header just sent
        n = sb.rx_hdr[14:12];
        for (int k = 0; k < n; k++) send_word(CMD_RX_OBJ, rand_pdo(), $urandom);
    endtask

    initial begin
        int opts [4] = '{0, 7, 6, 3};
        running = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        running = 1;

        write_reg(CFG_POWER_OPTION, 0);
        write_reg(CFG_PPS_VOLTAGE, 250);
        write_reg(CFG_PPS_CURRENT, 40);
        send_word(CMD_RX_OBJ, 32'hFFFF_FFFF, 3'd7);
        send_word(CMD_REQUEST, 0, 0);
        send_msg(0, 1, 0, 0);
        send_msg(0, 3, 0, 0);
        send_msg(0, 4, 0, 0);
        send_msg(0, 6, 0, 0);
        send_msg(0, 8, 0, 0);
        send_msg(0, 9, 0, 0);
        send_msg(0, 13, 0, 0);
        send_msg(0, 22, 0, 0);
        send_msg(0, 31, 0, 0);
        send_msg(0, 1, 7, 0);
        send_word(CMD_RX_OBJ, 32'h0001_912C, 0);
        send_word(CMD_RX_OBJ, 32'h0000_0000, 0);
        send_word(CMD_RX_OBJ, 32'hFFFF_FFFF, 0);
        send_word(CMD_RX_OBJ, 32'hC1A4_3264, 0);
        send_word(CMD_RX_OBJ, 32'h4000_0000, 0);
        send_word(CMD_RX_OBJ, 32'h8000_03FF, 0);
        send_word(CMD_RX_OBJ, 32'h3FFF_FFFF, 0);
        send_msg(1, 12, 2, 2);
        send_msg(1, 12, 3, 1);
        send_msg(0, 1, 0, 0);
        send_word(CMD_SELECT, 0, 3'd7);
        send_word(CMD_SELECT, 0, 3'd2);
        send_word(CMD_GET_SRC, 0, 0);
        send_word(CMD_GET_PPS, 0, 0);
        send_word(CMD_NOP, 0, 0);
        send_word(CMD_PRST, 0, 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = (ph == 1) ? 65 : (ph == 3) ? 19 : 0;
            rx_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 19 : 0;
            write_reg(CFG_POWER_OPTION, opts[ph]);
            write_reg(CFG_PPS_VOLTAGE, (ph == 1) ? 2047 : (ph == 0) ? 0 : $urandom_range(2047));
            write_reg(CFG_PPS_CURRENT, (ph == 1) ? 127 : (ph == 0) ? 0 : $urandom_range(127));
            if (ph == 2) hold_left = 300;
            while (sent < 10 + 100 * (ph + 1)) random_msg();
            drain();
        end

        running = 0;
        $display("tb_top: %0d words in, %0d words out, %0d source caps, %0d PPS status",
                 sb.words_in, sb.words_out, sb.caps_seen, sb.pps_seen);
        $display("tb_top: four power options, PPS settings at both extremes, idle and stall mixes");
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

/* usb_pd_sink_protocol_layer_core.f */
rtl/usbpd_pkg.sv
rtl/usb_pd_sink_protocol_layer_core.sv
verif/tb_top.sv
